// ----- rtl/sha_pkg.sv -----
package sha_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W = 3;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS = 64;
   localparam int DIGEST_WORDS = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int LEN_POS = 56;

   typedef logic [WORD_W-1:0] word_type;

   // Command from the front part to the back part.
   typedef enum logic [1:0] {
      CMD_BLOCK,   // compress the block, keep going
      CMD_FINAL    // compress the block, then emit the digest
   } cmd_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic [BLOCK_WORDS*WORD_W-1:0] block;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_ADD,
      BK_EMIT
   } bk_state_type;

   typedef enum logic [1:0] {
      FR_TAKE,
      FR_PAD,
      FR_LEN
   } fr_state_type;

   function automatic word_type rotr(word_type x, int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type round_k(logic [5:0] i);
      word_type k [ROUNDS] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      round_k = k[i];
   endfunction

   function automatic word_type init_hash(logic [2:0] i);
      word_type h [DIGEST_WORDS] = '{
         32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
      };
      init_hash = h[i];
   endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// SHA-256 streaming hasher.
// Input channel (req_*): one transaction per big-endian 32-bit message word,
// req_byte_count valid bytes from the top (honored only with req_last_word,
// otherwise four). req_last_word closes the message; a last transaction with
// zero bytes ends the message there.
// Result channel (rsp_*): eight transactions per message, digest words 0..7,
// rsp_digest_last on word 7.
// The front part packs bytes into a 64-byte block and adds the padding and
// the 64-bit bit length; whole blocks travel through a short queue to the
// back part, one compression unit doing one round per cycle.
// The front takes one word per cycle while the queue has room, but pauses while
// a finished block waits to enter the queue and while it adds the padding and
// the length. Reset clears the state registers, the fill and length counters,
// the queue pointers and the digest index, and loads the initial hash value.
// A stalled receiver holds the digest word; the compression unit waits, the
// queue fills and then req_ready drops.
module sha256_stream_hasher
   import sha_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0] req_byte_count,
   input  logic       req_last_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0] rsp_digest_index,
   output logic       rsp_digest_last
);

   job_type fr_job, bk_job;
   logic    fr_valid, fr_ready, bk_valid, bk_ready;

   // Assemble blocks and padding.
   sha_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data_word, .req_byte_count,
      .req_last_word, .job_valid(fr_valid), .job_ready(fr_ready), .job(fr_job)
   );

   // Decouple assembly from compression.
   sha_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .in_valid(fr_valid), .in_ready(fr_ready), .in_job(fr_job),
      .out_valid(bk_valid), .out_ready(bk_ready), .out_job(bk_job)
   );

   // Compress and emit the digest.
   sha_back u_back (
      .clock, .reset, .job_valid(bk_valid), .job_ready(bk_ready), .job(bk_job),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_digest_index, .rsp_digest_last
   );

endmodule

// ----- rtl/sha_front.sv -----
module sha_front
   import sha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  word_type req_data_word,
   input  logic [CNT_W-1:0] req_byte_count,
   input  logic     req_last_word,
   output logic     job_valid,
   input  logic     job_ready,
   output job_type  job
);

   // Byte-granular block assembly; bytes land at fill_ff.
   logic [7:0]  blk_ff [64];
   logic [7:0]  blk_in [64];
   logic [6:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   fr_state_type state_ff, state_in;
   logic        job_valid_ff, job_valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic [2:0]  nb;
   logic        fire;

   always_comb begin
      if (!req_last_word || req_byte_count > 3'd4) nb = 3'd4;
      else nb = req_byte_count;
   end

   assign req_ready = (state_ff == FR_TAKE) && !job_valid_ff;
   assign fire      = req_valid && req_ready;
   assign job_valid = job_valid_ff;

   always_comb begin
      for (int b = 0; b < 64; b++) job.block[(63-b)*8 +: 8] = blk_ff[b];
      job.cmd = cmd_ff;
   end

   always_comb begin
      blk_in       = blk_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      state_in     = state_ff;
      job_valid_in = job_valid_ff && !job_ready;
      cmd_in       = cmd_ff;
      unique case (state_ff)
         FR_TAKE: begin
            if (fire) begin
               for (int k = 0; k < 4; k++) begin
                  if (3'(k) < nb) blk_in[fill_ff[5:0] + 6'(k)] = req_data_word[31-8*k -: 8];
               end
               bits_in = bits_ff + 64'({nb, 3'b000});
               fill_in = fill_ff + 7'(nb);
               if (fill_in == 7'd64) begin
                  fill_in      = '0;
                  job_valid_in = 1'b1;
                  cmd_in       = CMD_BLOCK;
               end
               if (req_last_word) state_in = FR_PAD;
            end
         end
         FR_PAD: begin
            if (!job_valid_ff) begin
               blk_in[fill_ff[5:0]] = PAD_BYTE;
               for (int b = 0; b < 64; b++)
                  if (7'(b) > fill_ff) blk_in[b] = '0;
               if (fill_ff >= 7'(LEN_POS)) begin
                  job_valid_in = 1'b1;
                  cmd_in       = CMD_BLOCK;
                  fill_in      = '0;
                  state_in     = FR_LEN;
               end else begin
                  state_in = FR_LEN;
                  fill_in  = 7'd1;
               end
            end
         end
         FR_LEN: begin
            if (!job_valid_ff) begin
               if (fill_ff == '0)
                  for (int b = 0; b < LEN_POS; b++) blk_in[b] = '0;
               for (int b = 0; b < 8; b++) blk_in[LEN_POS+b] = bits_ff[63-8*b -: 8];
               job_valid_in = 1'b1;
               cmd_in       = CMD_FINAL;
               fill_in      = '0;
               bits_in      = '0;
               state_in     = FR_TAKE;
            end
         end
         default: state_in = FR_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      cmd_ff <= cmd_in;
      if (reset) begin
         fill_ff      <= '0;
         bits_ff      <= '0;
         state_ff     <= FR_TAKE;
         job_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         state_ff     <= state_in;
         job_valid_ff <= job_valid_in;
      end
   end

endmodule

// ----- rtl/sha_queue.sv -----
module sha_queue
   import sha_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_job;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/sha_back.sv -----
module sha_back
   import sha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   output logic     job_ready,
   input  job_type  job,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output word_type rsp_digest_word,
   output logic [2:0] rsp_digest_index,
   output logic     rsp_digest_last
);

   bk_state_type state_ff, state_in;
   word_type     h_ff [DIGEST_WORDS];
   word_type     h_in [DIGEST_WORDS];
   word_type     v_ff [DIGEST_WORDS];
   word_type     v_in [DIGEST_WORDS];
   word_type     w_ff [BLOCK_WORDS];
   word_type     w_in [BLOCK_WORDS];
   logic [5:0]   rnd_ff, rnd_in;
   logic [2:0]   idx_ff, idx_in;
   logic         fin_ff, fin_in;
   word_type     t1, t2, wn, s0, s1;

   // Rolling 16-word schedule window; w_ff[0] is the current round's word.
   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = s1 + w_ff[9] + s0 + w_ff[0];
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (job_valid) state_in = BK_ROUND;
         BK_ROUND: if (rnd_ff == 6'(ROUNDS-1)) state_in = BK_ADD;
         BK_ADD:   state_in = fin_ff ? BK_EMIT : BK_IDLE;
         BK_EMIT:  if (rsp_ready && idx_ff == 3'(DIGEST_WORDS-1)) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      h_in   = h_ff;
      v_in   = v_ff;
      w_in   = w_ff;
      rnd_in = rnd_ff;
      idx_in = idx_ff;
      fin_in = fin_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               for (int i = 0; i < BLOCK_WORDS; i++)
                  w_in[i] = job.block[(BLOCK_WORDS-1-i)*WORD_W +: WORD_W];
               v_in   = h_ff;
               rnd_in = '0;
               fin_in = (job.cmd == CMD_FINAL);
            end
         end
         BK_ROUND: begin
            for (int i = 0; i < BLOCK_WORDS-1; i++) w_in[i] = w_ff[i+1];
            w_in[BLOCK_WORDS-1] = wn;
            v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in  = rnd_ff + 1'b1;
         end
         BK_ADD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) h_in[i] = h_ff[i] + v_ff[i];
            idx_in = '0;
         end
         BK_EMIT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'(DIGEST_WORDS-1))
                  for (int i = 0; i < DIGEST_WORDS; i++) h_in[i] = init_hash(3'(i));
            end
         end
         default: ;
      endcase
   end

   assign job_ready        = state_ff == BK_IDLE;
   assign rsp_valid        = state_ff == BK_EMIT;
   assign rsp_digest_word  = h_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = idx_ff == 3'(DIGEST_WORDS-1);

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      w_ff   <= w_in;
      rnd_ff <= rnd_in;
      fin_ff <= fin_in;
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
         for (int i = 0; i < DIGEST_WORDS; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         h_ff     <= h_in;
      end
   end

endmodule
